[hdl/mer_pkg.sv]
// Shared constants and types for the midpoint ellipse rasterizer.
package mer_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;

  // Operation codes of an input item
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Walk phase of the point generator
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

endpackage

[hdl/midpoint_ellipse_rasterizer_top.sv]
// Top level of the midpoint ellipse rasterizer.
//
// Input channel (in_valid / in_stall): op selects start or advance. A start
// item carries the center and both radii and yields the first point set at
// once; each advance item yields the next set of four symmetric points.
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in order. point_valid is low for an advance while idle or for a start
// with a zero radius; last_set marks the final set of an ellipse.
// Pipeline: a result passes the input register, squaring stage, seed product
// stage and step stage before it is presented.
// Throughput: one item per cycle while the receiver does not stall; the step
// stage updates the decision value and the running ry^2*x and rx^2*y products
// with adds only.
// Reset (rst, synchronous) empties all stages and puts the walk back to idle.
// When the receiver stalls, the result register holds; stages behind it keep
// filling their empty slots and in_stall rises only once the input register
// cannot move on.
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [RADIUS_BITS-1:0]       radius_x,
  input  logic [RADIUS_BITS-1:0]       radius_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         point_valid,
  output logic signed [COORD_BITS+1:0] x_right,
  output logic signed [COORD_BITS+1:0] x_left,
  output logic signed [COORD_BITS+1:0] y_up,
  output logic signed [COORD_BITS+1:0] y_down,
  output logic                         region_two,
  output logic                         last_set
);

  localparam int SQ_W = 2 * RADIUS_BITS;
  localparam int SX_W = SQ_W + 3;
  localparam int PR_W = 3 * RADIUS_BITS;
  localparam int D_W  = 3 * RADIUS_BITS + 6;

  // Setup to step hand-off
  logic                   take;
  logic                   set_valid;
  logic                   set_op;
  logic                   set_zero;
  logic [COORD_BITS-1:0]  set_cx;
  logic [COORD_BITS-1:0]  set_cy;
  logic [RADIUS_BITS-1:0] set_rx;
  logic [RADIUS_BITS-1:0] set_ry;
  logic [SQ_W-1:0]        set_rx2;
  logic [SQ_W-1:0]        set_ry2;
  logic [SX_W-1:0]        set_six_rx2;
  logic [SX_W-1:0]        set_six_ry2;
  logic [PR_W-1:0]        set_rx2ry;
  logic [PR_W-1:0]        set_ry2rx;
  logic signed [D_W-1:0]  set_d1;
  logic signed [D_W-1:0]  set_d2;

  // Squares and seeds
  mer_setup #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_setup (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .take        (take),
    .set_valid   (set_valid),
    .set_op      (set_op),
    .set_zero    (set_zero),
    .set_cx      (set_cx),
    .set_cy      (set_cy),
    .set_rx      (set_rx),
    .set_ry      (set_ry),
    .set_rx2     (set_rx2),
    .set_ry2     (set_ry2),
    .set_six_rx2 (set_six_rx2),
    .set_six_ry2 (set_six_ry2),
    .set_rx2ry   (set_rx2ry),
    .set_ry2rx   (set_ry2rx),
    .set_d1      (set_d1),
    .set_d2      (set_d2)
  );

  // Point walk and result register
  mer_step #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .set_valid   (set_valid),
    .take        (take),
    .set_op      (set_op),
    .set_zero    (set_zero),
    .set_cx      (set_cx),
    .set_cy      (set_cy),
    .set_rx      (set_rx),
    .set_ry      (set_ry),
    .set_rx2     (set_rx2),
    .set_ry2     (set_ry2),
    .set_six_rx2 (set_six_rx2),
    .set_six_ry2 (set_six_ry2),
    .set_rx2ry   (set_rx2ry),
    .set_ry2rx   (set_ry2rx),
    .set_d1      (set_d1),
    .set_d2      (set_d2),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_valid (point_valid),
    .x_right     (x_right),
    .x_left      (x_left),
    .y_up        (y_up),
    .y_down      (y_down),
    .region_two  (region_two),
    .last_set    (last_set)
  );

endmodule

[hdl/mer_setup.sv]
// Setup pipeline: input register, radius squares, seed products and decision seeds.
module mer_setup #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic [COORD_BITS-1:0]              center_x,
  input  logic [COORD_BITS-1:0]              center_y,
  input  logic [RADIUS_BITS-1:0]             radius_x,
  input  logic [RADIUS_BITS-1:0]             radius_y,
  input  logic                               take,
  output logic                               set_valid,
  output logic                               set_op,
  output logic                               set_zero,
  output logic [COORD_BITS-1:0]              set_cx,
  output logic [COORD_BITS-1:0]              set_cy,
  output logic [RADIUS_BITS-1:0]             set_rx,
  output logic [RADIUS_BITS-1:0]             set_ry,
  output logic [2*RADIUS_BITS-1:0]           set_rx2,
  output logic [2*RADIUS_BITS-1:0]           set_ry2,
  output logic [2*RADIUS_BITS+2:0]           set_six_rx2,
  output logic [2*RADIUS_BITS+2:0]           set_six_ry2,
  output logic [3*RADIUS_BITS-1:0]           set_rx2ry,
  output logic [3*RADIUS_BITS-1:0]           set_ry2rx,
  output logic signed [3*RADIUS_BITS+5:0]    set_d1,
  output logic signed [3*RADIUS_BITS+5:0]    set_d2
);

  localparam int SQ_W = 2 * RADIUS_BITS;
  localparam int SX_W = SQ_W + 3;
  localparam int PR_W = 3 * RADIUS_BITS;
  localparam int D_W  = 3 * RADIUS_BITS + 6;

  // Stage 0: input register
  logic                   s0_valid;
  logic                   s0_op;
  logic [COORD_BITS-1:0]  s0_cx;
  logic [COORD_BITS-1:0]  s0_cy;
  logic [RADIUS_BITS-1:0] s0_rx;
  logic [RADIUS_BITS-1:0] s0_ry;

  // Stage 1: squares
  logic                   s1_valid;
  logic                   s1_op;
  logic                   s1_zero;
  logic [COORD_BITS-1:0]  s1_cx;
  logic [COORD_BITS-1:0]  s1_cy;
  logic [RADIUS_BITS-1:0] s1_rx;
  logic [RADIUS_BITS-1:0] s1_ry;
  logic [SQ_W-1:0]        s1_rx2;
  logic [SQ_W-1:0]        s1_ry2;

  // Stage 2 inputs
  logic [PR_W-1:0]        rx2ry;
  logic [PR_W-1:0]        ry2rx;
  logic signed [D_W-1:0]  d1_calc;
  logic signed [D_W-1:0]  d2_calc;
  logic [SX_W-1:0]        six_rx2_calc;
  logic [SX_W-1:0]        six_ry2_calc;

  logic s0_ready;
  logic s1_ready;
  logic s2_ready;

  // Ready chain: a stage loads when empty or when it moves on
  assign s2_ready = !set_valid || take;
  assign s1_ready = !s1_valid || s2_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign in_stall = !s0_ready;

  // Stage 0
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= in_valid;
    end
    if (s0_ready && in_valid) begin
      s0_op <= op;
      s0_cx <= center_x;
      s0_cy <= center_y;
      s0_rx <= radius_x;
      s0_ry <= radius_y;
    end
  end

  // Stage 1: square the radii
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s0_valid;
    end
    if (s1_ready && s0_valid) begin
      s1_op   <= s0_op;
      s1_zero <= (s0_rx == '0) || (s0_ry == '0);
      s1_cx   <= s0_cx;
      s1_cy   <= s0_cy;
      s1_rx   <= s0_rx;
      s1_ry   <= s0_ry;
      s1_rx2  <= SQ_W'(s0_rx) * SQ_W'(s0_rx);
      s1_ry2  <= SQ_W'(s0_ry) * SQ_W'(s0_ry);
    end
  end

  // Seed products and decision seeds for both regions
  always_comb begin
    rx2ry        = PR_W'(s1_rx2) * PR_W'(s1_ry);
    ry2rx        = PR_W'(s1_ry2) * PR_W'(s1_rx);
    d1_calc      = (D_W'(s1_ry2) <<< 1) + D_W'(s1_rx2) - (D_W'(rx2ry) <<< 1);
    d2_calc      = (D_W'(s1_rx2) <<< 1) + D_W'(s1_ry2) - (D_W'(ry2rx) <<< 1);
    six_rx2_calc = (SX_W'(s1_rx2) << 2) + (SX_W'(s1_rx2) << 1);
    six_ry2_calc = (SX_W'(s1_ry2) << 2) + (SX_W'(s1_ry2) << 1);
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      set_valid <= 1'b0;
    end else if (s2_ready) begin
      set_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      set_op      <= s1_op;
      set_zero    <= s1_zero;
      set_cx      <= s1_cx;
      set_cy      <= s1_cy;
      set_rx      <= s1_rx;
      set_ry      <= s1_ry;
      set_rx2     <= s1_rx2;
      set_ry2     <= s1_ry2;
      set_six_rx2 <= six_rx2_calc;
      set_six_ry2 <= six_ry2_calc;
      set_rx2ry   <= rx2ry;
      set_ry2rx   <= ry2rx;
      set_d1      <= d1_calc;
      set_d2      <= d2_calc;
    end
  end

endmodule

[hdl/mer_step.sv]
// Step unit: walk state, one midpoint step per item, and the result register.
module mer_step #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               set_valid,
  output logic                               take,
  input  logic                               set_op,
  input  logic                               set_zero,
  input  logic [COORD_BITS-1:0]              set_cx,
  input  logic [COORD_BITS-1:0]              set_cy,
  input  logic [RADIUS_BITS-1:0]             set_rx,
  input  logic [RADIUS_BITS-1:0]             set_ry,
  input  logic [2*RADIUS_BITS-1:0]           set_rx2,
  input  logic [2*RADIUS_BITS-1:0]           set_ry2,
  input  logic [2*RADIUS_BITS+2:0]           set_six_rx2,
  input  logic [2*RADIUS_BITS+2:0]           set_six_ry2,
  input  logic [3*RADIUS_BITS-1:0]           set_rx2ry,
  input  logic [3*RADIUS_BITS-1:0]           set_ry2rx,
  input  logic signed [3*RADIUS_BITS+5:0]    set_d1,
  input  logic signed [3*RADIUS_BITS+5:0]    set_d2,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               point_valid,
  output logic signed [COORD_BITS+1:0]       x_right,
  output logic signed [COORD_BITS+1:0]       x_left,
  output logic signed [COORD_BITS+1:0]       y_up,
  output logic signed [COORD_BITS+1:0]       y_down,
  output logic                               region_two,
  output logic                               last_set
);

  import mer_pkg::*;

  localparam int SQ_W  = 2 * RADIUS_BITS;
  localparam int SX_W  = SQ_W + 3;
  localparam int PR_W  = 3 * RADIUS_BITS;
  localparam int P_W   = 3 * RADIUS_BITS + 2;
  localparam int D_W   = 3 * RADIUS_BITS + 6;
  localparam int OUT_W = COORD_BITS + 2;

  // Walk state
  phase_t                 phase;
  logic [RADIUS_BITS-1:0] off_x;
  logic [RADIUS_BITS-1:0] off_y;
  logic signed [D_W-1:0]  decision;
  logic signed [P_W-1:0]  prod_x;   // ry^2 * x
  logic signed [P_W-1:0]  prod_y;   // rx^2 * y
  logic [COORD_BITS-1:0]  saved_cx;
  logic [COORD_BITS-1:0]  saved_cy;
  logic [RADIUS_BITS-1:0] saved_rx;
  logic [SQ_W-1:0]        rx2;
  logic [SQ_W-1:0]        ry2;
  logic [SX_W-1:0]        six_rx2;
  logic [SX_W-1:0]        six_ry2;
  logic [PR_W-1:0]        saved_ry2rx;
  logic signed [D_W-1:0]  saved_d2;

  // Working values after a possible start
  logic                   fire;
  logic                   start;
  phase_t                 cur_phase;
  logic [RADIUS_BITS-1:0] cur_x;
  logic [RADIUS_BITS-1:0] cur_y;
  logic signed [D_W-1:0]  cur_d;
  logic signed [P_W-1:0]  cur_px;
  logic signed [P_W-1:0]  cur_py;
  logic [COORD_BITS-1:0]  cur_cx;
  logic [COORD_BITS-1:0]  cur_cy;
  logic [RADIUS_BITS-1:0] cur_rx;
  logic [SQ_W-1:0]        cur_rx2;
  logic [SQ_W-1:0]        cur_ry2;
  logic [SX_W-1:0]        cur_six_rx2;
  logic [SX_W-1:0]        cur_six_ry2;
  logic [PR_W-1:0]        cur_ry2rx;
  logic signed [D_W-1:0]  cur_d2;

  // Step candidates for both regions
  logic                   dec_pos;
  logic signed [D_W-1:0]  ext_rx2;
  logic signed [D_W-1:0]  ext_ry2;
  logic signed [D_W-1:0]  ext_px;
  logic signed [D_W-1:0]  ext_py;
  logic signed [D_W-1:0]  r1_da;
  logic signed [D_W-1:0]  r1_db;
  logic [RADIUS_BITS-1:0] r1_x;
  logic [RADIUS_BITS-1:0] r1_y;
  logic signed [P_W-1:0]  r1_px;
  logic signed [P_W-1:0]  r1_py;
  logic                   r1_exit;
  logic signed [D_W-1:0]  r2_da;
  logic signed [D_W-1:0]  r2_db;
  logic [RADIUS_BITS-1:0] r2_x;
  logic [RADIUS_BITS-1:0] r2_y;
  logic signed [P_W-1:0]  r2_px;
  logic signed [P_W-1:0]  r2_py;
  logic                   r2_exit;

  // Next state
  phase_t                 phase_next;
  logic [RADIUS_BITS-1:0] off_x_next;
  logic [RADIUS_BITS-1:0] off_y_next;
  logic signed [D_W-1:0]  decision_next;
  logic signed [P_W-1:0]  prod_x_next;
  logic signed [P_W-1:0]  prod_y_next;

  // Result next values
  logic                   point_valid_next;
  logic [OUT_W-1:0]       x_right_next;
  logic [OUT_W-1:0]       x_left_next;
  logic [OUT_W-1:0]       y_up_next;
  logic [OUT_W-1:0]       y_down_next;
  logic                   region_two_next;
  logic                   last_set_next;

  // Handshake: the result register frees when taken
  assign take  = !out_valid || !out_stall;
  assign fire  = set_valid && take;
  assign start = (set_op == OP_START);

  // Load a new ellipse over the stored state on start
  always_comb begin
    cur_phase   = phase;
    cur_x       = off_x;
    cur_y       = off_y;
    cur_d       = decision;
    cur_px      = prod_x;
    cur_py      = prod_y;
    cur_cx      = saved_cx;
    cur_cy      = saved_cy;
    cur_rx      = saved_rx;
    cur_rx2     = rx2;
    cur_ry2     = ry2;
    cur_six_rx2 = six_rx2;
    cur_six_ry2 = six_ry2;
    cur_ry2rx   = saved_ry2rx;
    cur_d2      = saved_d2;
    if (start) begin
      if (set_zero) begin
        cur_phase = PH_IDLE;
      end else begin
        cur_phase   = PH_ONE;
        cur_x       = '0;
        cur_y       = set_ry;
        cur_d       = set_d1;
        cur_px      = '0;
        cur_py      = P_W'(set_rx2ry);
        cur_cx      = set_cx;
        cur_cy      = set_cy;
        cur_rx      = set_rx;
        cur_rx2     = set_rx2;
        cur_ry2     = set_ry2;
        cur_six_rx2 = set_six_rx2;
        cur_six_ry2 = set_six_ry2;
        cur_ry2rx   = set_ry2rx;
        cur_d2      = set_d2;
      end
    end
  end

  // Midpoint step for each region: adds on the running products only
  always_comb begin
    dec_pos = !cur_d[D_W-1];
    ext_rx2 = D_W'(cur_rx2);
    ext_ry2 = D_W'(cur_ry2);
    ext_px  = D_W'(cur_px);
    ext_py  = D_W'(cur_py);

    // region one: step x, y follows
    r1_da   = dec_pos ? cur_d + ((ext_rx2 - ext_py) <<< 2) : cur_d;
    r1_y    = dec_pos ? cur_y - 1'b1 : cur_y;
    r1_py   = dec_pos ? cur_py - P_W'(cur_rx2) : cur_py;
    r1_db   = r1_da + (ext_px <<< 2) + D_W'(cur_six_ry2);
    r1_x    = cur_x + 1'b1;
    r1_px   = cur_px + P_W'(cur_ry2);
    r1_exit = r1_px > r1_py;

    // region two: step y, x follows
    r2_da   = dec_pos ? cur_d + ((ext_ry2 - ext_px) <<< 2) : cur_d;
    r2_x    = dec_pos ? cur_x - 1'b1 : cur_x;
    r2_px   = dec_pos ? cur_px - P_W'(cur_ry2) : cur_px;
    r2_db   = r2_da + (ext_py <<< 2) + D_W'(cur_six_rx2);
    r2_y    = cur_y + 1'b1;
    r2_py   = cur_py + P_W'(cur_rx2);
    r2_exit = r2_py > r2_px;
  end

  // Next state
  always_comb begin
    phase_next    = cur_phase;
    off_x_next    = cur_x;
    off_y_next    = cur_y;
    decision_next = cur_d;
    prod_x_next   = cur_px;
    prod_y_next   = cur_py;
    unique case (cur_phase)
      PH_ONE: begin
        if (r1_exit) begin
          // hand over: region two restarts on the x axis
          phase_next    = PH_TWO;
          off_x_next    = cur_rx;
          off_y_next    = '0;
          decision_next = cur_d2;
          prod_x_next   = P_W'(cur_ry2rx);
          prod_y_next   = '0;
        end else begin
          off_x_next    = r1_x;
          off_y_next    = r1_y;
          decision_next = r1_db;
          prod_x_next   = r1_px;
          prod_y_next   = r1_py;
        end
      end
      PH_TWO: begin
        off_x_next    = r2_x;
        off_y_next    = r2_y;
        decision_next = r2_db;
        prod_x_next   = r2_px;
        prod_y_next   = r2_py;
        if (r2_exit) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Result of this item
  always_comb begin
    point_valid_next = 1'b0;
    x_right_next     = '0;
    x_left_next      = '0;
    y_up_next        = '0;
    y_down_next      = '0;
    region_two_next  = 1'b0;
    last_set_next    = 1'b0;
    unique case (cur_phase)
      PH_ONE, PH_TWO: begin
        point_valid_next = 1'b1;
        x_right_next     = OUT_W'(cur_cx) + OUT_W'(cur_x);
        x_left_next      = OUT_W'(cur_cx) - OUT_W'(cur_x);
        y_up_next        = OUT_W'(cur_cy) + OUT_W'(cur_y);
        y_down_next      = OUT_W'(cur_cy) - OUT_W'(cur_y);
        region_two_next  = (cur_phase == PH_TWO);
        last_set_next    = (cur_phase == PH_TWO) && r2_exit;
      end
      default: begin
        point_valid_next = 1'b0;
      end
    endcase
  end

  // Walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (fire) begin
      phase <= phase_next;
    end
    if (fire) begin
      off_x       <= off_x_next;
      off_y       <= off_y_next;
      decision    <= decision_next;
      prod_x      <= prod_x_next;
      prod_y      <= prod_y_next;
      saved_cx    <= cur_cx;
      saved_cy    <= cur_cy;
      saved_rx    <= cur_rx;
      rx2         <= cur_rx2;
      ry2         <= cur_ry2;
      six_rx2     <= cur_six_rx2;
      six_ry2     <= cur_six_ry2;
      saved_ry2rx <= cur_ry2rx;
      saved_d2    <= cur_d2;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      point_valid <= point_valid_next;
      x_right     <= x_right_next;
      x_left      <= x_left_next;
      y_up        <= y_up_next;
      y_down      <= y_down_next;
      region_two  <= region_two_next;
      last_set    <= last_set_next;
    end
  end

endmodule

[verif/midpoint_ellipse_rasterizer_top_tb.sv]
// Self-checking testbench for the midpoint ellipse rasterizer top level.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top_tb;
  import mer_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int RW = RADIUS_BITS_DEF;
  localparam int OW = CW + 2;
  localparam int RESULT_LATENCY = 3;
  localparam int CYCLE_LIMIT = 400000;

  // One result item: a set of four symmetric points
  typedef struct {
    logic                 pv;
    logic signed [OW-1:0] xr;
    logic signed [OW-1:0] xl;
    logic signed [OW-1:0] yu;
    logic signed [OW-1:0] yd;
    logic                 r2;
    logic                 last;
  } point_set_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          op = OP_ADVANCE;
  logic [CW-1:0] center_x = '0;
  logic [CW-1:0] center_y = '0;
  logic [RW-1:0] radius_x = '0;
  logic [RW-1:0] radius_y = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          point_valid;
  logic signed [OW-1:0] x_right;
  logic signed [OW-1:0] x_left;
  logic signed [OW-1:0] y_up;
  logic signed [OW-1:0] y_down;
  logic          region_two;
  logic          last_set;

  midpoint_ellipse_rasterizer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius_x   (radius_x),
    .radius_y   (radius_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_valid(point_valid),
    .x_right    (x_right),
    .x_left     (x_left),
    .y_up       (y_up),
    .y_down     (y_down),
    .region_two (region_two),
    .last_set   (last_set)
  );

  // Walk state mirrored from the accepted items
  phase_t  walk_phase = PH_IDLE;
  longint  step_x = 0;
  longint  step_y = 0;
  longint  decision_acc = 0;
  longint  rx_sq = 0;
  longint  ry_sq = 0;
  longint  held_cx = 0;
  longint  held_cy = 0;
  longint  held_rx = 0;

  point_set_t expected_sets[$];
  point_set_t oldest_set;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Next point set of the walk for one accepted item
  function automatic point_set_t next_point_set(logic op_i, logic [CW-1:0] cx,
                                                logic [CW-1:0] cy, logic [RW-1:0] rx,
                                                logic [RW-1:0] ry);
    point_set_t ps;
    ps = '{default: '0};
    if (op_i == OP_START) begin
      if (rx == 0 || ry == 0) begin
        walk_phase = PH_IDLE;
        return ps;
      end
      held_cx = longint'(cx);
      held_cy = longint'(cy);
      held_rx = longint'(rx);
      rx_sq = longint'(rx) * longint'(rx);
      ry_sq = longint'(ry) * longint'(ry);
      step_x = 0;
      step_y = longint'(ry);
      decision_acc = 2 * ry_sq + rx_sq * (1 - 2 * longint'(ry));
      walk_phase = PH_ONE;
    end
    if (walk_phase == PH_IDLE) return ps;

    ps.pv = 1'b1;
    ps.xr = OW'(held_cx + step_x);
    ps.xl = OW'(held_cx - step_x);
    ps.yu = OW'(held_cy + step_y);
    ps.yd = OW'(held_cy - step_y);
    ps.r2 = (walk_phase == PH_TWO);

    if (walk_phase == PH_ONE) begin
      // region one: step x, y drops when the decision is non-negative
      if (decision_acc >= 0) begin
        decision_acc += 4 * rx_sq * (1 - step_y);
        step_y--;
      end
      decision_acc += ry_sq * (4 * step_x + 6);
      step_x++;
      if (!(ry_sq * step_x <= rx_sq * step_y)) begin
        walk_phase = PH_TWO;
        step_x = held_rx;
        step_y = 0;
        decision_acc = 2 * rx_sq + ry_sq * (1 - 2 * held_rx);
      end
    end else begin
      // region two: step y from the x axis, x drops on non-negative decision
      if (decision_acc >= 0) begin
        decision_acc += 4 * ry_sq * (1 - step_x);
        step_x--;
      end
      decision_acc += rx_sq * (4 * step_y + 6);
      step_y++;
      if (!(rx_sq * step_y <= ry_sq * step_x)) begin
        ps.last = 1'b1;
        walk_phase = PH_IDLE;
      end
    end
    return ps;
  endfunction

  // Drive one item, wait for it to be taken, record its expected point set
  task automatic send_item(logic op_i, logic [CW-1:0] cx, logic [CW-1:0] cy,
                           logic [RW-1:0] rx, logic [RW-1:0] ry);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op       <= op_i;
    center_x <= cx;
    center_y <= cy;
    radius_x <= rx;
    radius_y <= ry;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_sets.push_back(next_point_set(op_i, cx, cy, rx, ry));
  endtask

  // Advance items carry junk in the fields the block ignores
  task automatic send_advance();
    send_item(OP_ADVANCE, CW'($urandom), CW'($urandom), RW'($urandom), RW'($urandom));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_sets.size() != 0) @(posedge clk);
  endtask

  function automatic logic [RW-1:0] short_radius();
    if ($urandom_range(99) < 85) return RW'($urandom_range(1, 24));
    return RW'($urandom_range(25, 90));
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Edges of every field, both regions, idle advances, zero radii, restarts
  task automatic test_directed();
    send_advance();
    send_item(OP_START, 0, 0, 1, 1);
    send_advance();
    send_advance();
    send_item(OP_START, 4095, 4095, 2047, 2047);
    repeat (3) send_advance();
    send_item(OP_START, 0, 4095, 2047, 1);
    repeat (3) send_advance();
    send_item(OP_START, 4095, 0, 1, 2047);
    repeat (2) send_advance();
    send_item(OP_START, 100, 200, 0, 5);
    send_advance();
    send_item(OP_START, 300, 400, 5, 0);
    send_item(OP_START, 500, 600, 0, 0);
    send_item(OP_START, 2048, 2047, 3, 2);
    while (walk_phase != PH_IDLE) send_advance();
    wait_all_results();
  endtask

  // Mostly complete ellipses with random content, plus restarts and noise
  task automatic test_random_walks(int n_items);
    int sent;
    int pick;
    int steps;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_item(OP_START, CW'($urandom), CW'($urandom), short_radius(), short_radius());
        sent++;
        while (walk_phase != PH_IDLE) begin
          send_advance();
          sent++;
        end
      end else if (pick < 88) begin
        // big radii: only the first steps, then abandoned
        send_item(OP_START, CW'($urandom), CW'($urandom), RW'($urandom_range(1, 2047)),
                  RW'($urandom_range(1, 2047)));
        steps = $urandom_range(0, 15);
        repeat (steps) send_advance();
        sent += steps + 1;
      end else if (pick < 93) begin
        send_advance();
        sent++;
      end else if (pick < 97) begin
        steps = $urandom_range(0, 2);
        send_item(OP_START, CW'($urandom), CW'($urandom),
                  (steps == 1) ? RW'($urandom) : RW'(0),
                  (steps == 0) ? RW'($urandom) : RW'(0));
        sent++;
      end else begin
        send_item(OP_START, CW'($urandom), CW'($urandom), short_radius(), short_radius());
        steps = $urandom_range(0, 6);
        repeat (steps) send_advance();
        sent += steps + 1;
      end
    end
    wait_all_results();
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_input_backpressure();
    int sent;
    set_idling(0, 0);
    hold_left = 120;
    sent = 0;
    while (sent < 40) begin
      if (walk_phase == PH_IDLE)
        send_item(OP_START, CW'($urandom), CW'($urandom), short_radius(), short_radius());
      else
        send_advance();
      sent++;
    end
    wait_all_results();
  endtask

  // Sender waits for every result before offering the next item
  task automatic test_sender_pause();
    set_idling(0, 30);
    send_item(OP_START, CW'($urandom), CW'($urandom), 6, 4);
    while (walk_phase != PH_IDLE) begin
      wait_all_results();
      send_advance();
    end
    wait_all_results();
  endtask

  // Receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each taken result against the oldest expectation
  task automatic compare_field(string name, logic signed [15:0] want,
                               logic signed [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_sets.size() == 0) begin
        $error("result item with nothing expected");
        mismatch_count++;
      end else begin
        oldest_set = expected_sets.pop_front();
        compare_field("point_valid", 16'(oldest_set.pv), 16'(point_valid));
        compare_field("x_right", 16'(oldest_set.xr), 16'(x_right));
        compare_field("x_left", 16'(oldest_set.xl), 16'(x_left));
        compare_field("y_up", 16'(oldest_set.yu), 16'(y_up));
        compare_field("y_down", 16'(oldest_set.yd), 16'(y_down));
        compare_field("region_two", 16'(oldest_set.r2), 16'(region_two));
        compare_field("last_set", 16'(oldest_set.last), 16'(last_set));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    set_idling(0, 0);
    test_random_walks(250);
    set_idling(70, 0);
    test_random_walks(250);
    set_idling(0, 70);
    test_random_walks(250);
    set_idling(11, 11);
    test_random_walks(250);
    test_input_backpressure();
    test_sender_pause();

    // let any stray result show up
    wait_all_results();
    repeat (RESULT_LATENCY * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mer_pkg.sv
hdl/mer_setup.sv
hdl/mer_step.sv
hdl/midpoint_ellipse_rasterizer_top.sv
verif/midpoint_ellipse_rasterizer_top_tb.sv
